/* rtl/core/sst_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted set table package
// Shared constants, transaction types, status codes and control types.
// ----------------------------------------------------------------------------
package sst_pkg;

    // Number of entries the table can hold.
    localparam int CAPACITY = 64;

    // Width of the entry counter, wide enough to hold CAPACITY itself.
    localparam int COUNT_W = $clog2(CAPACITY + 1);

    // Width of a stored value.
    localparam int VALUE_W = 32;

    // Operation codes carried in the func field.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } status_e_t;

    // Request transaction.
    typedef struct packed {
        logic                      func;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    // Response transaction.
    typedef struct packed {
        logic [2:0] status;
        logic [6:0] entry_count;
    } rsp_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic cmp;
        logic upd;
    } cmd_t;

endpackage

/* rtl/core/sst_ctrl.sv */
// ----------------------------------------------------------------------------
// Sorted set table controller
// Sequences the capture, compare and update steps of each transaction and
// owns the handshake on both channels.
// ----------------------------------------------------------------------------
module sst_ctrl
    import sst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    output logic rsp_valid,
    input  logic rsp_stall,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   rsp_free;

    // The response register can take a new result when empty or being drained.
    assign rsp_free = !rsp_valid_reg || !rsp_stall;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (rsp_free)
                begin
                    state_next = req_valid ? S_CMP : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output logic: a new transaction may enter while the previous one retires.
    always_comb
    begin
        req_stall = 1'b1;
        cmd       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
            end
            S_CMP:
            begin
                cmd.cmp = 1'b1;
            end
            S_UPD:
            begin
                req_stall = !rsp_free;
                cmd.upd   = rsp_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
        cmd.load = req_valid && !req_stall;
    end

    // Response valid is set by an update and cleared when the result is taken.
    always_comb
    begin
        if (cmd.upd)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    // An accepted request always proceeds to the compare step.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_CMP)
        else $error("accepted request did not enter compare");

    // An update never overwrites a result that is still held.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.upd |-> !(rsp_valid_reg && rsp_stall))
        else $error("update would overwrite a stalled result");

    // A result appears only as the outcome of an update.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(cmd.upd))
        else $error("result valid without an update");

endmodule

/* rtl/core/sst_datapath.sv */
// ----------------------------------------------------------------------------
// Sorted set table datapath
// A row of value cells with a broadcast compare and a one-place shift up or
// down, plus the entry counter and the response register.
// ----------------------------------------------------------------------------
module sst_datapath
    import sst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cmd_t cmd,
    input  req_t req,
    output rsp_t rsp
);

    logic                func_reg;
    logic                func_next;
    logic [VALUE_W-1:0]  value_reg;
    logic [VALUE_W-1:0]  value_next;
    logic [CAPACITY-1:0] lt_reg;
    logic [CAPACITY-1:0] lt_next;
    logic [CAPACITY-1:0] eq_vec;
    logic                found_reg;
    logic                found_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [COUNT_W-1:0]  count_next;
    logic [VALUE_W-1:0]  cell_reg [CAPACITY];
    logic [VALUE_W-1:0]  cell_next [CAPACITY];
    rsp_t                rsp_reg;
    rsp_t                rsp_next;
    logic                full;
    logic                do_ins;
    logic                do_del;
    status_e_t           status;

    // Request capture.
    assign func_next  = cmd.load ? req.func : func_reg;
    assign value_next = cmd.load ? req.value : value_reg;

    // Broadcast compare: each occupied cell reports below and equal.
    // The below flags form a run from cell zero because the row is sorted.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cmp
        logic occupied;
        assign occupied   = COUNT_W'(i) < count_reg;
        assign lt_next[i] = occupied && ($signed(cell_reg[i]) < $signed(value_reg));
        assign eq_vec[i]  = occupied && (cell_reg[i] == value_reg);
    end

    assign found_next = |eq_vec;
    assign full       = count_reg == COUNT_W'(CAPACITY);

    // Decide the outcome of the operation from the registered compare.
    always_comb
    begin
        do_ins = 1'b0;
        do_del = 1'b0;
        if (func_reg == FUNC_INSERT)
        begin
            if (found_reg)
            begin
                status = ST_DUPLICATE;
            end
            else if (full)
            begin
                status = ST_FULL;
            end
            else
            begin
                status = ST_INSERTED;
                do_ins = cmd.upd;
            end
        end
        else
        begin
            if (found_reg)
            begin
                status = ST_DELETED;
                do_del = cmd.upd;
            end
            else
            begin
                status = ST_NOT_FOUND;
            end
        end
    end

    // Cell shift: cells below the position hold, the rest move one place.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [VALUE_W-1:0] from_below;
        logic [VALUE_W-1:0] from_above;
        logic               at_pos;

        if (i == 0)
        begin : g_first
            assign from_below = value_reg;
            assign at_pos     = 1'b1;
        end
        else
        begin : g_inner
            assign from_below = cell_reg[i-1];
            assign at_pos     = lt_reg[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign from_above = cell_reg[i];
        end
        else
        begin : g_upper
            assign from_above = cell_reg[i+1];
        end

        always_comb
        begin
            cell_next[i] = cell_reg[i];
            if (!lt_reg[i])
            begin
                if (do_ins)
                begin
                    cell_next[i] = at_pos ? value_reg : from_below;
                end
                else if (do_del)
                begin
                    cell_next[i] = from_above;
                end
            end
        end
    end

    // Entry count update.
    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (do_del)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    // Response register.
    always_comb
    begin
        rsp_next = rsp_reg;
        if (cmd.upd)
        begin
            rsp_next.status      = status;
            rsp_next.entry_count = 7'(count_next);
        end
    end

    // Request capture, compare flag and response registers.
    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        value_reg <= value_next;
        rsp_reg   <= rsp_next;
        if (cmd.cmp)
        begin
            lt_reg    <= lt_next;
            found_reg <= found_next;
        end
    end

    // Cell row storage.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cell_reg[i] <= cell_next[i];
        end
    end

    // Entry counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign rsp = rsp_reg;

    // The count never exceeds the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // A sorted row yields below flags that run unbroken from cell zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.cmp) |-> ((lt_reg >> 1) & ~lt_reg) == '0)
        else $error("compare flags not a prefix, row out of order");

    // A successful delete lowers the count by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        do_del |=> count_reg == $past(count_reg) - COUNT_W'(1))
        else $error("delete did not lower the count by one");

endmodule

/* rtl/core/sorted_set_table.sv */
// A result is registered after the capture, compare and update steps of its request.
// A new request can be accepted in the update step of the previous one while results are
// taken; the compare step over the cell row and the following shift step limit the rate.
// Reset clears the entry counter and control state; the cells are not cleared,
// and the table is usable straight after reset with no clearing pass.
// ----------------------------------------------------------------------------
// Sorted set table
// Keeps distinct signed 32-bit values in ascending order with insert and
// delete requests, reporting a status and the entry count for each.
// ----------------------------------------------------------------------------
module sorted_set_table
    import sst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    cmd_t cmd;

    // Sequencing of each transaction.
    sst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    // Cell row, counter and response register.
    sst_datapath u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
